>>> rtl/pncs_pkg.sv
package pncs_pkg;

  // Field widths
  localparam int COLOR_W = 8;
  localparam int CHAN6_W = 6;
  localparam int INDEX_W = 8;
  localparam int DIST_W  = 18;
  localparam int SQ_W    = 2 * COLOR_W;

  // Default palette depth
  localparam int DEF_PALETTE_ENTRIES = 256;

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Input word
  typedef struct packed {
    logic               mode;
    logic [INDEX_W-1:0] entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pncs_in_t;

  // Result word
  typedef struct packed {
    logic [INDEX_W-1:0] nearest_index;
    logic [DIST_W-1:0]  best_distance;
  } pncs_out_t;

  // Stored 6-bit channel widened back to 8 bits: {v, v[5:4]}
  function automatic logic [COLOR_W-1:0] expand6(input logic [CHAN6_W-1:0] v);
    expand6 = {v, v[CHAN6_W-1 -: (COLOR_W - CHAN6_W)]};
  endfunction

  // Squared distance of one channel
  function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                              input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    sq_diff = d * d;
  endfunction

endpackage

>>> rtl/palette_nearest_color_search_unit.sv
// Nearest palette color search.
// Input channel (in_valid / in_stall / in_data) carries one word per item.
// A write word (mode 0) stores the color cut to 6 bits per channel at
// entry_index; an index beyond the palette is dropped. Writes give no result.
// A query word (mode 1) scans every palette entry, one memory read per
// cycle, and returns the lowest index at the smallest squared RGB distance
// together with that distance.
// A query's scan is paced by the single read port of the palette memory;
// the read, square and compare stages then lie between the scan and the
// result in the output register.
// in_stall is high from query acceptance until the result moves into the
// output register; writes can follow each other every cycle.
// Output channel (out_valid / out_stall / out_data): the result stays in its
// register while out_stall is high; the next item is still accepted then,
// but a second query result waits in the search unit until the register
// frees.
// Reset: all palette entries read as zero (per-entry valid bits cleared),
// no result pending, block idle in the first cycle after reset.
module palette_nearest_color_search_unit #(
  parameter int PALETTE_ENTRIES = pncs_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pncs_pkg::pncs_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pncs_pkg::pncs_out_t out_data
);

  localparam int IDX_W   = $clog2(PALETTE_ENTRIES);
  localparam int ENT_W   = 3 * pncs_pkg::CHAN6_W;
  localparam int C6      = pncs_pkg::CHAN6_W;
  localparam int CW      = pncs_pkg::COLOR_W;
  localparam int SQW     = pncs_pkg::SQ_W;
  localparam int DW      = pncs_pkg::DIST_W;

  // Sequencer codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0] state_r, state_nxt;

  // Palette memory and per-entry valid bits
  logic [ENT_W-1:0]           pal_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] ent_vld_r;

  logic             in_acc;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [ENT_W-1:0] wr_ent;

  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic             addr_last;

  // Query color
  logic [CW-1:0] q_red_r, q_green_r, q_blue_r;

  // Read stage
  logic             s1_vld_r, s1_last_r, s1_ok_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [ENT_W-1:0] rd_data_r;
  logic [CW-1:0]    e_red, e_green, e_blue;

  // Square stage
  logic             s2_vld_r, s2_last_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [SQW-1:0]   sq_red_r, sq_green_r, sq_blue_r;

  // Compare stage
  logic [DW-1:0]    cand_d;
  logic             take;
  logic [DW-1:0]    best_d_r;
  logic [IDX_W-1:0] best_idx_r;

  // Output register
  logic                out_valid_r;
  pncs_pkg::pncs_out_t out_data_r;
  logic                out_free;
  logic                out_load;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (in_data.mode == pncs_pkg::MODE_WRITE) &&
                    ({1'b0, in_data.entry_index} < (pncs_pkg::INDEX_W + 1)'(PALETTE_ENTRIES));
  assign wr_idx   = in_data.entry_index[IDX_W-1:0];
  assign wr_ent   = {in_data.red[CW-1 -: C6], in_data.green[CW-1 -: C6],
                     in_data.blue[CW-1 -: C6]};

  assign addr_last = (addr_r == IDX_W'(PALETTE_ENTRIES - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_HOLD) && out_free;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      ST_IDLE: begin
        addr_nxt = '0;
        if (in_acc && (in_data.mode == pncs_pkg::MODE_QUERY)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s2_vld_r && s2_last_r) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    addr_r <= addr_nxt;
  end

  // Latch query color
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.mode == pncs_pkg::MODE_QUERY)) begin
      q_red_r   <= in_data.red;
      q_green_r <= in_data.green;
      q_blue_r  <= in_data.blue;
    end
  end

  // Write an entry and mark it valid
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal_mem[wr_idx] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (wr_en) begin
      ent_vld_r[wr_idx] <= 1'b1;
    end
  end

  // Read one entry per scan cycle
  always_ff @(posedge clk) begin
    rd_data_r <= pal_mem[addr_r];
    s1_ok_r   <= ent_vld_r[addr_r];
    s1_idx_r  <= addr_r;
    s1_last_r <= addr_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= (state_r == ST_SCAN);
      s2_vld_r <= s1_vld_r;
    end
  end

  // Expand entry; an unwritten entry reads as black
  assign e_red   = s1_ok_r ? pncs_pkg::expand6(rd_data_r[3*C6-1 -: C6]) : '0;
  assign e_green = s1_ok_r ? pncs_pkg::expand6(rd_data_r[2*C6-1 -: C6]) : '0;
  assign e_blue  = s1_ok_r ? pncs_pkg::expand6(rd_data_r[C6-1 -: C6])   : '0;

  // Square the channel differences
  always_ff @(posedge clk) begin
    sq_red_r   <= pncs_pkg::sq_diff(q_red_r, e_red);
    sq_green_r <= pncs_pkg::sq_diff(q_green_r, e_green);
    sq_blue_r  <= pncs_pkg::sq_diff(q_blue_r, e_blue);
    s2_idx_r   <= s1_idx_r;
    s2_last_r  <= s1_last_r;
  end

  // Sum and keep the first strictly smaller distance
  assign cand_d = DW'(sq_red_r) + DW'(sq_green_r) + DW'(sq_blue_r);
  assign take   = s2_vld_r && ((s2_idx_r == '0) || (cand_d < best_d_r));

  always_ff @(posedge clk) begin
    if (take) begin
      best_d_r   <= cand_d;
      best_idx_r <= s2_idx_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.nearest_index <= pncs_pkg::INDEX_W'(best_idx_r);
      out_data_r.best_distance <= best_d_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> dv/tb_palette_nearest_color_search_unit.sv
module tb_palette_nearest_color_search_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES      = pncs_pkg::DEF_PALETTE_ENTRIES;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = ENTRIES + 16;
  localparam int PHASE_ITEMS  = 400;

  // One row of the directed table; typed rows carry their own result
  typedef struct {
    pncs_pkg::pncs_in_t  word;
    bit                  typed;
    pncs_pkg::pncs_out_t result;
  } stim_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  pncs_pkg::pncs_in_t  in_data   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  pncs_pkg::pncs_out_t out_data;

  // Shadow palette and the queue of pending search results
  logic [23:0]         pal_color [ENTRIES];
  pncs_pkg::pncs_out_t nearest_q [$];
  pncs_pkg::pncs_out_t want;

  int err_count      = 0;
  int idle_cycles    = 0;
  int send_idle_pct  = 8;
  int recv_stall_pct = 84;

  palette_nearest_color_search_unit #(
    .PALETTE_ENTRIES(ENTRIES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // Cut a channel to 6 bits and widen it back by repeating the top bits
  function automatic logic [7:0] widen6(input logic [7:0] c);
    logic [7:0] v;
    v = c >> 2;
    widen6 = (v << 2) | (v >> 4);
  endfunction

  task automatic store_entry(input logic [7:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
    if (int'(idx) < ENTRIES) begin
      pal_color[idx] = {widen6(r), widen6(g), widen6(b)};
    end
  endtask

  // Scan the shadow palette; only a strictly smaller distance wins
  function automatic pncs_pkg::pncs_out_t nearest_color(input logic [7:0] r,
                                                        input logic [7:0] g,
                                                        input logic [7:0] b);
    pncs_pkg::pncs_out_t res;
    int best_d;
    int best_i;
    int dr;
    int dg;
    int db;
    int d;
    bit hit;
    best_d = 1 << 30;
    best_i = 0;
    hit    = 1'b0;
    for (int i = 0; i < ENTRIES && !hit; i++) begin
      dr = int'(r) - int'(pal_color[i][23:16]);
      dg = int'(g) - int'(pal_color[i][15:8]);
      db = int'(b) - int'(pal_color[i][7:0]);
      d  = dr * dr + dg * dg + db * db;
      if (d < best_d) begin
        best_d = d;
        best_i = i;
        if (d == 0) hit = 1'b1;
      end
    end
    res.nearest_index = best_i[7:0];
    res.best_distance = best_d[17:0];
    return res;
  endfunction

  function automatic stim_row_t row(input logic mode, input logic [7:0] idx,
                                    input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input bit typed,
                                    input logic [7:0] ni, input logic [17:0] bd);
    stim_row_t s;
    s.word.mode          = mode;
    s.word.entry_index   = idx;
    s.word.red           = r;
    s.word.green         = g;
    s.word.blue          = b;
    s.typed              = typed;
    s.result.nearest_index = ni;
    s.result.best_distance = bd;
    return s;
  endfunction

  // Mostly legal traffic aimed at stored colors, near misses, ties and extremes
  function automatic pncs_pkg::pncs_in_t random_word();
    pncs_pkg::pncs_in_t w;
    logic [23:0]        c;
    logic [31:0]        bits;
    int                 pick;
    bits          = $urandom;
    c             = 24'($urandom);
    pick          = $urandom_range(0, 99);
    w.entry_index = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 55) begin
      w.mode = pncs_pkg::MODE_WRITE;
      if (pick < 10) begin
        c = pal_color[$urandom_range(0, ENTRIES - 1)];
      end else if (pick < 25) begin
        c = {{8{bits[0]}}, {8{bits[1]}}, {8{bits[2]}}};
      end
    end else begin
      w.mode = pncs_pkg::MODE_QUERY;
      if (pick < 30) begin
        c = pal_color[$urandom_range(0, ENTRIES - 1)];
      end else if (pick < 50) begin
        c = pal_color[$urandom_range(0, ENTRIES - 1)] ^ (bits[23:0] & 24'h030303);
      end else if (pick < 60) begin
        c = {{8{bits[0]}}, {8{bits[1]}}, {8{bits[2]}}};
      end
    end
    w.red   = c[23:16];
    w.green = c[15:8];
    w.blue  = c[7:0];
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  // Offer one word, hold it until taken, then update the shadow state
  task automatic send_word(input pncs_pkg::pncs_in_t w, input bit typed,
                           input pncs_pkg::pncs_out_t typed_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (w.mode == pncs_pkg::MODE_WRITE) begin
      store_entry(w.entry_index, w.red, w.green, w.blue);
    end else if (typed) begin
      nearest_q.push_back(typed_res);
    end else begin
      nearest_q.push_back(nearest_color(w.red, w.green, w.blue));
    end
  endtask

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Compare each taken result with the oldest pending one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (nearest_q.size() == 0) begin
        report_mismatch($sformatf("result idx=%0d dist=%0d with no query pending",
                                  out_data.nearest_index, out_data.best_distance));
      end else begin
        want = nearest_q.pop_front();
        if (out_data.nearest_index !== want.nearest_index) begin
          report_mismatch($sformatf("nearest_index got %0d want %0d",
                                    out_data.nearest_index, want.nearest_index));
        end
        if (out_data.best_distance !== want.best_distance) begin
          report_mismatch($sformatf("best_distance got %0d want %0d",
                                    out_data.best_distance, want.best_distance));
        end
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t           dir_rows [$];
    pncs_pkg::pncs_out_t none;
    none = '0;
    foreach (pal_color[i]) pal_color[i] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Cleared palette: black matches at zero, white at the far corner
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'h00, 8'hff, 8'hff, 8'hff, 1'b1,
                           8'd0, 18'd195075));
    // Top entry white, then an exact hit on it
    dir_rows.push_back(row(pncs_pkg::MODE_WRITE, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'h00, 8'hff, 8'hff, 8'hff, 1'b1,
                           8'd255, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'h00, 8'h80, 8'h80, 8'h80, 1'b0,
                           8'd0, 18'd0));
    // Low bits lost when cut to 6 bits
    dir_rows.push_back(row(pncs_pkg::MODE_WRITE, 8'h00, 8'h03, 8'h03, 8'h03, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'h00, 8'h03, 8'h03, 8'h03, 1'b0,
                           8'd0, 18'd0));
    // Primaries
    dir_rows.push_back(row(pncs_pkg::MODE_WRITE, 8'h01, 8'hff, 8'h00, 8'h00, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_WRITE, 8'h02, 8'h00, 8'hff, 8'h00, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_WRITE, 8'h03, 8'h00, 8'h00, 8'hff, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'h00, 8'hff, 8'h00, 8'h00, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'h00, 8'h00, 8'hff, 8'h00, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'h00, 8'h00, 8'h00, 8'hff, 1'b0,
                           8'd0, 18'd0));
    // Mid-scale channels around the widening boundary
    dir_rows.push_back(row(pncs_pkg::MODE_WRITE, 8'h80, 8'h7f, 8'h80, 8'h81, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'h00, 8'h7f, 8'h80, 8'h81, 1'b0,
                           8'd0, 18'd0));
    // Two entries with one color: the lower index must win
    dir_rows.push_back(row(pncs_pkg::MODE_WRITE, 8'h0a, 8'haa, 8'h55, 8'haa, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_WRITE, 8'h14, 8'haa, 8'h55, 8'haa, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'h00, 8'ha9, 8'h56, 8'hab, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_WRITE, 8'hfe, 8'h5b, 8'hc4, 8'h37, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'h00, 8'h5a, 8'hc6, 8'h36, 1'b0,
                           8'd0, 18'd0));
    // Entry zero turns white too: zero-distance tie at both ends
    dir_rows.push_back(row(pncs_pkg::MODE_WRITE, 8'h00, 8'hff, 8'hff, 8'hfe, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0,
                           8'd0, 18'd0));
    // Index field is don't-care on a query
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_WRITE, 8'h55, 8'h55, 8'haa, 8'h55, 1'b0,
                           8'd0, 18'd0));
    dir_rows.push_back(row(pncs_pkg::MODE_QUERY, 8'haa, 8'h55, 8'haa, 8'h55, 1'b0,
                           8'd0, 18'd0));

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].result);

    // Random traffic under three idling mixes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 8;
          recv_stall_pct = 84;
        end
        1: begin
          send_idle_pct  = 84;
          recv_stall_pct = 8;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (PHASE_ITEMS) send_word(random_word(), 1'b0, none);
    end
    in_valid <= 1'b0;

    // Drain pending results, then watch for stray ones
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && nearest_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
